// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the tracker RTL. Every macro
// expects a clock named clk and an active-low reset named arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TKBVT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tracker check failed");

// Next-cycle implication, checked outside reset.
`define TKBVT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tracker check failed");

`endif

// File: rtl/core/tkbvt_pkg.sv
// ----------------------------------------------------------------------------
// Top-K bound violation tracker package
// Field widths, operation codes and the payload types shared by the tracker
// modules.
// ----------------------------------------------------------------------------
package tkbvt_pkg;

	localparam int INDEX_W = 24;
	localparam int VALUE_W = 32;
	localparam int RANK_W  = 4;
	localparam int LIMIT_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

	// Operation carried by each request.
	typedef enum logic [1:0] {
		OP_OFFER = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Read-out sequencer states.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	// One incoming request.
	typedef struct packed {
		op_t                        operation;
		logic [INDEX_W-1:0]         item_index;
		logic signed [VALUE_W-1:0]  item_value;
		logic signed [VALUE_W-1:0]  bound_low;
		logic signed [VALUE_W-1:0]  bound_high;
		logic                       low_present;
		logic                       high_present;
	} item_t;

	// One outgoing result.
	typedef struct packed {
		logic [RANK_W-1:0]          rank;
		logic [INDEX_W-1:0]         entry_number;
		logic [VALUE_W-1:0]         violation_amount;
		logic signed [VALUE_W-1:0]  entry_value;
		logic signed [VALUE_W-1:0]  entry_low;
		logic signed [VALUE_W-1:0]  entry_high;
		logic                       entry_low_present;
		logic                       entry_high_present;
		logic                       last_of_run;
		logic                       list_empty;
	} result_t;

	// Contents of one list slot.
	typedef struct packed {
		logic [INDEX_W-1:0]         number;
		logic [VALUE_W-1:0]         violation;
		logic signed [VALUE_W-1:0]  value;
		logic signed [VALUE_W-1:0]  low;
		logic signed [VALUE_W-1:0]  high;
		logic                       low_present;
		logic                       high_present;
	} slot_t;

	// Per-cell control from the list controller.
	typedef struct packed {
		logic insert;
		logic occupied;
	} cell_ctl_t;

endpackage

// File: rtl/core/tkbvt_viol_stage.sv
// ----------------------------------------------------------------------------
// Violation stage
// Registers each accepted request and computes its bound violation,
// max(0, low - value, value - high), with absent bounds left out.
// ----------------------------------------------------------------------------
module tkbvt_viol_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  tkbvt_pkg::item_t    item,
	output logic                valid_s1,
	output tkbvt_pkg::op_t      op_s1,
	output tkbvt_pkg::slot_t    entry_s1,
	output logic                hit_s1
);

	localparam int WIDE_W = tkbvt_pkg::VALUE_W + 1;

	logic signed [WIDE_W-1:0] val_w;
	logic signed [WIDE_W-1:0] low_diff;
	logic signed [WIDE_W-1:0] high_diff;
	logic signed [WIDE_W-1:0] viol;
	tkbvt_pkg::slot_t         entry_d;

	// Differences in one extra bit so that they cannot overflow.
	always_comb begin
		val_w     = WIDE_W'(item.item_value);
		low_diff  = WIDE_W'(item.bound_low) - val_w;
		high_diff = val_w - WIDE_W'(item.bound_high);
		viol      = '0;
		if (item.low_present && (low_diff > viol)) begin
			viol = low_diff;
		end
		if (item.high_present && (high_diff > viol)) begin
			viol = high_diff;
		end
	end

	// Slot image of the request.
	always_comb begin
		entry_d.number       = item.item_index;
		entry_d.violation    = viol[tkbvt_pkg::VALUE_W-1:0];
		entry_d.value        = item.item_value;
		entry_d.low          = item.bound_low;
		entry_d.high         = item.bound_high;
		entry_d.low_present  = item.low_present;
		entry_d.high_present = item.high_present;
	end

	// Stage valid; every stage-one request is consumed in its cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= item.operation;
			entry_s1 <= entry_d;
			hit_s1   <= (viol != '0);
		end
	end

endmodule

// File: rtl/core/tkbvt_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one slot of the sorted list. On an insertion a cell that ranks below
// the new entry either takes the new entry or the slot of its left neighbor.
// ----------------------------------------------------------------------------
module tkbvt_cell (
	input  logic                  clk,
	input  tkbvt_pkg::cell_ctl_t  ctl,
	input  tkbvt_pkg::slot_t      new_entry,
	input  tkbvt_pkg::slot_t      left_slot,
	input  logic                  left_ahead,
	output logic                  ahead,
	output tkbvt_pkg::slot_t      slot
);

	tkbvt_pkg::slot_t slot_q;

	// The new entry goes ahead of this slot when the slot is empty, its
	// violation is smaller, or the violations tie and the new index is lower.
	always_comb begin
		ahead = !ctl.occupied
			|| (new_entry.violation > slot_q.violation)
			|| ((new_entry.violation == slot_q.violation)
				&& (new_entry.number < slot_q.number));
	end

	// Shift right from the neighbor, or load the new entry at the insert point.
	always_ff @(posedge clk) begin
		if (ctl.insert && ahead) begin
			slot_q <= left_ahead ? left_slot : new_entry;
		end
	end

	assign slot = slot_q;

endmodule

// File: rtl/core/top_k_bound_violation_tracker.sv
// ----------------------------------------------------------------------------
// Top-K bound violation tracker
// Offers, clears and read-outs over a sorted list held in a row of cells.
// ----------------------------------------------------------------------------
// Offer and clear requests are taken one per clock while no read is active.
// The violation is computed as the request is accepted and registered with it
// in the stage-one register, and from there inserted into the row of MAX_KEPT
// cells, all cells comparing in parallel. A read request holds off new
// requests until it is done and emits one result per cycle, while the result
// side does not stall, from the single cell-select port: fill_count results
// (one result for an empty list). The configuration channel is always ready.
module top_k_bound_violation_tracker #(
	parameter int MAX_KEPT = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  tkbvt_pkg::item_t                      item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output tkbvt_pkg::result_t                    result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tkbvt_pkg::LIMIT_W-1:0]         cfg_data
);

	`include "assert_macros.svh"

	localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W = $clog2(MAX_KEPT + 1);

	logic                            take;
	logic                            valid_s1;
	tkbvt_pkg::op_t                  op_s1;
	tkbvt_pkg::slot_t                entry_s1;
	logic                            hit_s1;

	logic [tkbvt_pkg::LIMIT_W-1:0]   keep_limit_q;
	logic [CNT_W-1:0]                fill_count_q;
	logic [CNT_W-1:0]                lim;
	logic [CNT_W:0]                  fill_inc;
	logic [CNT_W-1:0]                fill_next;
	logic                            insert;

	logic [MAX_KEPT:0]               before_chain;
	tkbvt_pkg::slot_t                cell_slot [MAX_KEPT];

	tkbvt_pkg::state_t               state_q;
	tkbvt_pkg::state_t               state_d;
	logic [IDX_W-1:0]                ptr_q;
	logic                            load;
	logic                            last;
	tkbvt_pkg::slot_t                sel;
	tkbvt_pkg::result_t              result_d;
	tkbvt_pkg::result_t              result_q;
	logic                            result_valid_q;
	logic                            read_pending;

	// Front stage: request register and violation arithmetic.
	tkbvt_viol_stage u_viol (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (item),
		.valid_s1 (valid_s1),
		.op_s1    (op_s1),
		.entry_s1 (entry_s1),
		.hit_s1   (hit_s1)
	);

	assign take = item_valid && item_ready;

	// Configuration register; writes must arrive only while idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit_q <= tkbvt_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			keep_limit_q <= cfg_data;
		end
	end

	// Effective limit and the fill count after a successful insertion.
	always_comb begin
		if (32'(keep_limit_q) > MAX_KEPT) begin
			lim = CNT_W'(MAX_KEPT);
		end else begin
			lim = CNT_W'(keep_limit_q);
		end
		fill_inc = {1'b0, fill_count_q} + (CNT_W + 1)'(1);
		if (fill_inc > {1'b0, lim}) begin
			fill_next = lim;
		end else begin
			fill_next = fill_inc[CNT_W-1:0];
		end
		insert = valid_s1 && (op_s1 == tkbvt_pkg::OP_OFFER) && hit_s1 && (lim != '0);
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
		end else if (valid_s1 && (op_s1 == tkbvt_pkg::OP_CLEAR)) begin
			fill_count_q <= '0;
		end else if (insert) begin
			fill_count_q <= fill_next;
		end
	end

	// Row of cells; the insert-point flag and the slot data pass rightward.
	assign before_chain[0] = 1'b0;

	for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
		tkbvt_pkg::cell_ctl_t ctl;
		tkbvt_pkg::slot_t     left_slot;

		assign ctl.insert   = insert;
		assign ctl.occupied = CNT_W'(i) < fill_count_q;

		if (i == 0) begin : g_head
			assign left_slot = entry_s1;
		end else begin : g_body
			assign left_slot = cell_slot[i-1];
		end

		tkbvt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (entry_s1),
			.left_slot  (left_slot),
			.left_ahead (before_chain[i]),
			.ahead      (before_chain[i+1]),
			.slot       (cell_slot[i])
		);
	end

	// Read-out sequencer: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tkbvt_pkg::ST_IDLE: begin
				if (read_pending) begin
					state_d = tkbvt_pkg::ST_READ;
				end
			end
			tkbvt_pkg::ST_READ: begin
				if (load && last) begin
					state_d = tkbvt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tkbvt_pkg::ST_IDLE;
			end
		endcase
	end

	// Read-out sequencer: outputs.
	always_comb begin
		read_pending = valid_s1 && (op_s1 == tkbvt_pkg::OP_READ);
		load         = 1'b0;
		item_ready   = 1'b0;
		case (state_q)
			tkbvt_pkg::ST_IDLE: begin
				item_ready = !read_pending;
			end
			tkbvt_pkg::ST_READ: begin
				load = !result_valid_q || result_ready;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	// Result for the current read pointer, or the empty marker.
	always_comb begin
		sel  = cell_slot[ptr_q];
		last = (fill_count_q == '0) || ((CNT_W'(ptr_q) + CNT_W'(1)) == fill_count_q);
		result_d = '0;
		if (fill_count_q == '0) begin
			result_d.last_of_run = 1'b1;
			result_d.list_empty  = 1'b1;
		end else begin
			result_d.rank               = tkbvt_pkg::RANK_W'(ptr_q);
			result_d.entry_number       = sel.number;
			result_d.violation_amount   = sel.violation;
			result_d.entry_value        = sel.value;
			result_d.entry_low          = sel.low;
			result_d.entry_high         = sel.high;
			result_d.entry_low_present  = sel.low_present;
			result_d.entry_high_present = sel.high_present;
			result_d.last_of_run        = last;
		end
	end

	// Sequencer state, read pointer and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tkbvt_pkg::ST_IDLE;
			ptr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				result_valid_q <= 1'b1;
				ptr_q          <= last ? '0 : ptr_q + IDX_W'(1);
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A clear empties the list by the next cycle.
	`TKBVT_ASSERT_NEXT(a_clear_empties, valid_s1 && (op_s1 == tkbvt_pkg::OP_CLEAR), fill_count_q == '0)
	// The list never holds more entries than there are cells.
	`TKBVT_ASSERT_NOW(a_fill_bound, 1'b1, 32'(fill_count_q) <= MAX_KEPT)
	// An insertion grows the list by at most one entry.
	`TKBVT_ASSERT_NEXT(a_fill_step, insert, (CNT_W + 1)'(fill_count_q) <= $past(fill_inc))
	// An empty marker is always the final result of its read-out.
	`TKBVT_ASSERT_NOW(a_empty_last, result_valid && result.list_empty, result.last_of_run && (result.rank == '0))

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Top-K bound violation tracker testbench
// A table of directed requests, then random offer, read and clear requests
// under several keep limits. Every read-out is checked field by field against
// its table entry or a behavioral model of the sorted worst-violation list.
// Requests are sent in bursts and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

	import tkbvt_pkg::*;

	localparam int KEEP_DEPTH = 16;

	// A directed request, with its single result where it is obvious.
	typedef struct {
		item_t   req;
		logic    typed;
		result_t want;
	} directed_row_t;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	item_t              item         = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	result_t            result;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data     = '0;

	// Behavioral copy of the list and its limit.
	slot_t   tracked_slot [KEEP_DEPTH];
	int      tracked_count = 0;
	int      tracked_limit = int'(LIMIT_RESET);

	result_t awaited_results[$];
	int      mismatch_count = 0;

	// Directed request table.
	directed_row_t plan[$];

	// Result side stall pattern.
	int      stall_left     = 0;
	int      stall_mode     = 0;
	int      receiver_cycle = 0;

	top_k_bound_violation_tracker #(
		.MAX_KEPT(KEEP_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("top_k_bound_violation_tracker: mismatch");
		$finish;
	end

	function automatic item_t make_request(op_t op, logic [INDEX_W-1:0] idx,
			logic [VALUE_W-1:0] val, logic [VALUE_W-1:0] lo,
			logic [VALUE_W-1:0] hi, logic lp, logic hp);
		item_t r;
		r.operation    = op;
		r.item_index   = idx;
		r.item_value   = val;
		r.bound_low    = lo;
		r.bound_high   = hi;
		r.low_present  = lp;
		r.high_present = hp;
		return r;
	endfunction

	function automatic result_t empty_read();
		result_t r;
		r = '0;
		r.last_of_run = 1'b1;
		r.list_empty  = 1'b1;
		return r;
	endfunction

	// The only result of a read of a one-entry list.
	function automatic result_t single_entry(logic [INDEX_W-1:0] num,
			logic [VALUE_W-1:0] viol, logic [VALUE_W-1:0] val,
			logic [VALUE_W-1:0] lo, logic [VALUE_W-1:0] hi, logic lp, logic hp);
		result_t r;
		r = '0;
		r.entry_number       = num;
		r.violation_amount   = viol;
		r.entry_value        = val;
		r.entry_low          = lo;
		r.entry_high         = hi;
		r.entry_low_present  = lp;
		r.entry_high_present = hp;
		r.last_of_run        = 1'b1;
		return r;
	endfunction

	// Appends one result to the awaited queue.
	function automatic void await_result(result_t r);
		awaited_results = {awaited_results, r};
	endfunction

	// Appends one row to the directed table.
	function automatic void add_row(item_t req, logic typed, result_t want);
		directed_row_t row;
		row.req   = req;
		row.typed = typed;
		row.want  = want;
		plan = {plan, row};
	endfunction

	// Applies one request to the list and queues the read-out it causes.
	function automatic void worst_list_step(item_t req);
		longint             viol, v, lo, hi;
		logic [VALUE_W-1:0] amount;
		int                 lim, pos, newcount;
		result_t            res;
		case (req.operation)
			OP_OFFER: begin
				v    = $signed(req.item_value);
				lo   = $signed(req.bound_low);
				hi   = $signed(req.bound_high);
				viol = 0;
				if (req.low_present && lo - v > viol)
					viol = lo - v;
				if (req.high_present && v - hi > viol)
					viol = v - hi;
				lim = (tracked_limit > KEEP_DEPTH) ? KEEP_DEPTH : tracked_limit;
				if (viol > 0 && lim != 0) begin
					amount = viol[VALUE_W-1:0];
					// Find the first entry that the new one outranks.
					pos = 0;
					while (pos < tracked_count && pos < KEEP_DEPTH &&
							!(amount > tracked_slot[pos].violation ||
							(amount == tracked_slot[pos].violation &&
							req.item_index < tracked_slot[pos].number)))
						pos++;
					newcount = (tracked_count + 1 > lim) ? lim : tracked_count + 1;
					tracked_count = newcount;
					if (pos < newcount) begin
						for (int i = newcount - 1; i > pos; i--)
							tracked_slot[i] = tracked_slot[i-1];
						tracked_slot[pos].number       = req.item_index;
						tracked_slot[pos].violation    = amount;
						tracked_slot[pos].value        = req.item_value;
						tracked_slot[pos].low          = req.bound_low;
						tracked_slot[pos].high         = req.bound_high;
						tracked_slot[pos].low_present  = req.low_present;
						tracked_slot[pos].high_present = req.high_present;
					end
				end
			end
			OP_READ: begin
				if (tracked_count == 0) begin
					await_result(empty_read());
				end else begin
					for (int k = 0; k < tracked_count; k++) begin
						res = '0;
						res.rank               = k[RANK_W-1:0];
						res.entry_number       = tracked_slot[k].number;
						res.violation_amount   = tracked_slot[k].violation;
						res.entry_value        = tracked_slot[k].value;
						res.entry_low          = tracked_slot[k].low;
						res.entry_high         = tracked_slot[k].high;
						res.entry_low_present  = tracked_slot[k].low_present;
						res.entry_high_present = tracked_slot[k].high_present;
						res.last_of_run        = (k + 1 == tracked_count);
						await_result(res);
					end
				end
			end
			OP_CLEAR: begin
				tracked_count = 0;
			end
			default: begin
			end
		endcase
	endfunction

	// A Q16.16 value, half the time a whole number near zero so that ties are common.
	function automatic logic [VALUE_W-1:0] random_q();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			3:       return VALUE_W'(int'($urandom_range(0, 255)) - 128);
			default: return VALUE_W'((int'($urandom_range(0, 16)) - 8) <<< 16);
		endcase
	endfunction

	function automatic item_t random_request();
		int                 pick;
		op_t                op;
		logic [INDEX_W-1:0] idx;
		pick = $urandom_range(0, 99);
		if (pick < 78)
			op = OP_OFFER;
		else if (pick < 90)
			op = OP_READ;
		else if (pick < 95)
			op = OP_CLEAR;
		else
			op = OP_NONE;
		if ($urandom_range(0, 1) == 0)
			idx = INDEX_W'($urandom_range(0, 7));
		else
			idx = INDEX_W'($urandom);
		return make_request(op, idx, random_q(), random_q(), random_q(),
			1'($urandom), 1'($urandom));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Holds one request on the input until it is taken.
	task automatic send_request(input item_t req, input logic typed,
			input result_t want);
		item_valid <= 1'b1;
		item       <= req;
		do
			@(posedge clk);
		while (!item_ready);
		if (typed)
			await_result(want);
		else
			worst_list_step(req);
	endtask

	// Stops sending and waits until every result is in.
	task automatic drain_results();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Writes the keep limit once the list has settled.
	task automatic write_limit(input logic [LIMIT_W-1:0] limit);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= limit;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracked_limit = int'(limit);
	endtask

	// Result side stalls: free running, occasional short stalls, or heavy.
	always @(posedge clk) begin
		receiver_cycle++;
		if (receiver_cycle % 97 == 0)
			stall_mode = $urandom_range(0, 2);
		if (stall_left > 0)
			stall_left--;
		else if (stall_mode == 1 && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 3);
		else if (stall_mode == 2 && $urandom_range(0, 2) == 0)
			stall_left = $urandom_range(1, 6);
		result_ready <= (stall_left == 0);
	end

	// Compare each accepted result with the oldest one awaited.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result, rank", 32'(result.rank), 32'd0);
			end else begin
				want = awaited_results.pop_front();
				check_field("rank", 32'(result.rank), 32'(want.rank));
				check_field("entry_number", 32'(result.entry_number),
					32'(want.entry_number));
				check_field("violation_amount", result.violation_amount,
					want.violation_amount);
				check_field("entry_value", result.entry_value, want.entry_value);
				check_field("entry_low", result.entry_low, want.entry_low);
				check_field("entry_high", result.entry_high, want.entry_high);
				check_field("entry_low_present", 32'(result.entry_low_present),
					32'(want.entry_low_present));
				check_field("entry_high_present", 32'(result.entry_high_present),
					32'(want.entry_high_present));
				check_field("last_of_run", 32'(result.last_of_run),
					32'(want.last_of_run));
				check_field("list_empty", 32'(result.list_empty),
					32'(want.list_empty));
			end
		end
	end

	initial begin
		logic [LIMIT_W-1:0]   phase_limit[$];
		int                   burst_left;
		int                   gap;

		for (int i = 0; i < KEEP_DEPTH; i++)
			tracked_slot[i] = '0;

		// Directed requests under the reset limit.
		add_row(make_request(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, empty_read());
		add_row(make_request(OP_CLEAR, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 1, 1), 1'b0, '0);
		add_row(make_request(OP_NONE, 24'hFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1, 0), 1'b0, '0);
		add_row(make_request(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, empty_read());
		// Lower bound violation at the widest span.
		add_row(make_request(OP_OFFER, 24'hFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1, 0), 1'b0, '0);
		add_row(make_request(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1,
			single_entry(24'hFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1, 0));
		add_row(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		// Upper bound violation at the widest span.
		add_row(make_request(OP_OFFER, 0, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 0, 1), 1'b0, '0);
		add_row(make_request(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1,
			single_entry(0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 0, 1));
		add_row(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		// Both bounds absent, inside the bounds, and right on a bound: no entry.
		add_row(make_request(OP_OFFER, 5, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0),
			1'b0, '0);
		add_row(make_request(OP_OFFER, 6, 0, 32'hFFFFFFFF, 1, 1, 1), 1'b0, '0);
		add_row(make_request(OP_OFFER, 8, 32'h00010000, 32'h00010000,
			32'h00010000, 1, 1), 1'b0, '0);
		add_row(make_request(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, empty_read());
		// Crossed bounds, then ties on violation and on index.
		add_row(make_request(OP_OFFER, 7, 0, 32'h00050000, 32'hFFFD0000, 1, 1),
			1'b0, '0);
		add_row(make_request(OP_OFFER, 3, 0, 32'h00050000, 0, 1, 0), 1'b0, '0);
		add_row(make_request(OP_OFFER, 3, 32'h00010000, 32'h00060000, 0, 1, 0),
			1'b0, '0);
		add_row(make_request(OP_OFFER, 9, 32'h7FFFFFFF, 0, 0, 0, 1), 1'b0, '0);
		add_row(make_request(OP_OFFER, 1, 0, 1, 0, 1, 0), 1'b0, '0);
		add_row(make_request(OP_READ, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(make_request(OP_NONE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(make_request(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(make_request(OP_READ, 0, 0, 0, 0, 0, 0), 1'b1, empty_read());

		// Limits for the random phases, largest before a small one so that
		// a lowered limit meets a long list.
		phase_limit = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd5, 5'd10};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_request(plan[i].req, plan[i].typed, plan[i].want);

		burst_left = 0;
		foreach (phase_limit[p]) begin
			write_limit(phase_limit[p]);
			// Read what the new limit leaves before any insertion.
			send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0), 1'b0, '0);
			for (int n = 0; n < 60; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if ($urandom_range(0, 19) == 0) begin
						drain_results();
					end else if (gap > 0) begin
						item_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				burst_left--;
				send_request(random_request(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("top_k_bound_violation_tracker: match");
		else
			$display("top_k_bound_violation_tracker: mismatch");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tkbvt_pkg.sv
rtl/core/tkbvt_viol_stage.sv
rtl/core/tkbvt_cell.sv
rtl/core/top_k_bound_violation_tracker.sv
tb/sv/tb.sv
